// ===== hdl/mmnb_pkg.sv =====
// Shared types, constants and codes for the min-max normalize-to-byte block.
package mmnb_pkg;

    localparam int STORE_DEPTH_DEFAULT = 4096;

    localparam int SAMPLE_W   = 16;
    localparam int COORD_W    = 10;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int PIXEL_W    = 8;
    localparam int ADDR_W     = 20;
    localparam int STATUS_W   = 2;
    localparam int IDX_W      = COORD_W + CFG_W + 1;
    localparam int NUM_W      = SAMPLE_W + PIXEL_W;
    localparam int DEN_W      = SAMPLE_W;

    localparam int S_TDATA_W  = 40;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 32;
    localparam int M_TUSER_W  = STATUS_W;

    localparam logic [CFG_W-1:0] CFG_RESET_VALUE = CFG_W'(64);

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_INDEX_ERR = 2'd1,
        STATUS_FLAT      = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_LENGTH   = 2'd0,
        REG_ROW_COUNT    = 2'd1,
        REG_BITMAP_WIDTH = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [PIXEL_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== hdl/mmnb_store.sv =====
// Sample store: single-port-write, registered-read memory of frame samples.
module mmnb_store #(
    parameter int STORE_DEPTH = mmnb_pkg::STORE_DEPTH_DEFAULT,
    parameter int AW          = $clog2(STORE_DEPTH)
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [mmnb_pkg::SAMPLE_W-1:0] wr_data,
    input  logic                          rd_en,
    input  logic [AW-1:0]                 rd_addr,
    output logic [mmnb_pkg::SAMPLE_W-1:0] rd_data
);
    import mmnb_pkg::*;

    logic [SAMPLE_W-1:0] mem [STORE_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/mmnb_div.sv =====
// Restoring divider that produces an 8-bit quotient, one bit per cycle.
module mmnb_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  mmnb_pkg::div_req_t req,
    output mmnb_pkg::div_rsp_t rsp
);
    import mmnb_pkg::*;

    localparam int DSH_W = DEN_W + PIXEL_W - 1;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [2:0]           cnt_reg, cnt_next;
    logic [NUM_W-1:0]     rem_reg, rem_next;
    logic [DSH_W-1:0]     dsh_reg, dsh_next;
    logic [PIXEL_W-1:0]   quo_reg, quo_next;
    logic                 ge;

    assign ge = rem_reg >= NUM_W'(dsh_reg);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = 3'd7;
            rem_next  = req.num;
            dsh_next  = {req.den, (PIXEL_W-1)'(0)};
            quo_next  = '0;
        end else if (busy_reg) begin
            rem_next = ge ? rem_reg - NUM_W'(dsh_reg) : rem_reg;
            quo_next = {quo_reg[PIXEL_W-2:0], ge};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 3'd1;
            if (cnt_reg == 3'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== hdl/minmax_normalize_to_byte.sv =====
// Min-max contrast stretch: sample store, running min/max and the read sequencer.
// Load requests (tuser operation 0) may follow back to back while the sequencer is idle; a load
// into a full store is dropped. A read request (operation 1) passes through index and address
// arithmetic, the range check while the sample memory is read, the difference to the minimum,
// scaling by 255 with the start of the divider, the bit-serial divider (eight quotient bits and
// its done flag) and the load of the output register. The sequencer takes no new request until a
// read has loaded its result and returned to idle. A read that fails the range check or finds a
// flat frame goes from the range check straight to the output load, and a read of a zero sample
// skips the divider. The result sits in an output register, so a new request is taken while it
// waits; a finished read that finds that register still full holds the input until it drains.
// Registers are to be written through the cfg port only while the block is idle; the block itself
// does not enforce this, and cfg_ready is always high.
module minmax_normalize_to_byte #(
    parameter int STORE_DEPTH = mmnb_pkg::STORE_DEPTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // sample[15:0], column[25:16], row[35:26], zero fill above
    input  logic [mmnb_pkg::S_TDATA_W-1:0] s_tdata,
    // operation[0], frame_start[1]
    input  logic [mmnb_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // pixel[7:0], address[27:8], zero fill above
    output logic [mmnb_pkg::M_TDATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [mmnb_pkg::M_TUSER_W-1:0] m_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mmnb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mmnb_pkg::CFG_W-1:0]     cfg_data
);
    import mmnb_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_COUNT = CW'(STORE_DEPTH);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_CALC   = 7'b0000010,
        ST_CHECK  = 7'b0000100,
        ST_FETCH  = 7'b0001000,
        ST_SCALE  = 7'b0010000,
        ST_DIVIDE = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]    row_length_reg, row_count_reg, bitmap_width_reg;
    logic [CW-1:0]       count_reg, count_next;
    logic [SAMPLE_W-1:0] min_reg, min_next, max_reg, max_next;

    logic [COORD_W-1:0]  col_reg, row_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic                range_err_reg;
    logic [DEN_W-1:0]    diff_reg;
    logic                zero_reg;
    logic [PIXEL_W-1:0]  pixel_reg, pixel_next;
    status_t             status_reg, status_next;

    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;

    logic                s_accept, load_accept, read_accept, out_free;
    logic                store_wr_en, store_rd_en;
    logic [CW-1:0]       count_eff;
    logic [SAMPLE_W-1:0] s_sample, rd_data;
    logic [COORD_W-1:0]  s_column, s_row;
    logic                flat;
    logic [DEN_W-1:0]    range_den;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    assign s_sample = s_tdata[15:0];
    assign s_column = s_tdata[25:16];
    assign s_row    = s_tdata[35:26];

    assign s_tready    = (state_reg == ST_IDLE);
    assign s_accept    = s_tvalid && s_tready;
    assign load_accept = s_accept && (s_tuser[0] == OP_LOAD);
    assign read_accept = s_accept && (s_tuser[0] == OP_READ);
    assign out_free    = !m_tvalid_reg || m_tready;
    assign cfg_ready   = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_length_reg   <= CFG_RESET_VALUE;
            row_count_reg    <= CFG_RESET_VALUE;
            bitmap_width_reg <= CFG_RESET_VALUE;
        end else if (cfg_valid && cfg_ready) begin
            unique case (reg_idx_t'(cfg_index))
                REG_ROW_LENGTH:   row_length_reg   <= cfg_data;
                REG_ROW_COUNT:    row_count_reg    <= cfg_data;
                REG_BITMAP_WIDTH: bitmap_width_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Load path: a frame start empties the frame before the sample is taken.
    assign count_eff   = s_tuser[1] ? '0 : count_reg;
    assign store_wr_en = load_accept && (count_eff < DEPTH_COUNT);

    always_comb begin
        count_next = count_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        if (load_accept && s_tuser[1]) begin
            count_next = '0;
            min_next   = '0;
            max_next   = '0;
        end
        if (store_wr_en) begin
            count_next = count_eff + CW'(1);
            if (count_eff == '0) begin
                min_next = s_sample;
                max_next = s_sample;
            end else begin
                if ($signed(s_sample) > $signed(max_reg)) max_next = s_sample;
                if ($signed(s_sample) < $signed(min_reg)) min_next = s_sample;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
        end else begin
            count_reg <= count_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
        end
    end

    assign store_rd_en = (state_reg == ST_CHECK);

    mmnb_store #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (store_wr_en),
        .wr_addr (count_eff[AW-1:0]),
        .wr_data (s_sample),
        .rd_en   (store_rd_en),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign flat      = (max_reg == min_reg);
    assign range_den = max_reg - min_reg;

    assign div_req.start = (state_reg == ST_SCALE) && !zero_reg;
    assign div_req.num   = {diff_reg, PIXEL_W'(0)} - NUM_W'(diff_reg);
    assign div_req.den   = range_den;

    mmnb_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        state_next  = state_reg;
        pixel_next  = pixel_reg;
        status_next = status_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (read_accept) state_next = ST_CALC;
            end
            ST_CALC: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                pixel_next = '0;
                if (range_err_reg || (idx_reg >= IDX_W'(count_reg))) begin
                    status_next = STATUS_INDEX_ERR;
                    state_next  = ST_FINISH;
                end else if (flat) begin
                    status_next = STATUS_FLAT;
                    state_next  = ST_FINISH;
                end else begin
                    status_next = STATUS_OK;
                    state_next  = ST_FETCH;
                end
            end
            ST_FETCH: begin
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                state_next = zero_reg ? ST_FINISH : ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (div_rsp.done) begin
                    pixel_next = div_rsp.quotient;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (read_accept) begin
            col_reg <= s_column;
            row_reg <= s_row;
        end
        if (state_reg == ST_CALC) begin
            idx_reg       <= IDX_W'(col_reg) + IDX_W'(row_reg * row_length_reg);
            addr_reg      <= ADDR_W'(ADDR_W'(col_reg) + ADDR_W'(row_reg * bitmap_width_reg));
            range_err_reg <= (CFG_W'(col_reg) >= row_length_reg)
                          || (CFG_W'(row_reg) >= row_count_reg);
        end
        if (state_reg == ST_FETCH) begin
            diff_reg <= rd_data - min_reg;
            zero_reg <= (rd_data == '0);
        end
        pixel_reg  <= pixel_next;
        status_reg <= status_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_FINISH && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FINISH && out_free) begin
            m_tdata_reg <= M_TDATA_W'({addr_reg, pixel_reg});
            m_tuser_reg <= status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_div_done_in_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_DIVIDE))
        else $error("divider finished outside the divide state");

    a_store_write_on_load: assert property (@(posedge aclk) disable iff (!aresetn)
        store_wr_en |-> (s_tvalid && s_tready && (s_tuser[0] == OP_LOAD)))
        else $error("sample store written without a load request");

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_COUNT)
        else $error("sample count beyond store depth");

    a_min_not_above_max: assert property (@(posedge aclk) disable iff (!aresetn)
        $signed(min_reg) <= $signed(max_reg))
        else $error("frame minimum above frame maximum");

    a_finish_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && out_free) |=> (m_tvalid && state_reg == ST_IDLE))
        else $error("finished read did not reach the output register");

endmodule
